[design/rate_threshold_interpolator_assert.svh]
// Assertion macros used by the port-level checker of the rate threshold interpolator.
`ifndef RATE_THRESHOLD_INTERPOLATOR_ASSERT_SVH
`define RATE_THRESHOLD_INTERPOLATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define RTI_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define RTI_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/rti_pkg.sv]
// Shared types and constants of the rate threshold interpolator.
package rti_pkg;

  localparam int CFG_W   = 5;
  localparam int IDX_W   = 4;
  localparam int DATA_W  = 32;
  localparam int RATE_W  = 32;

  // Item opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // One quotient step per bit of the 33-bit limit difference
  localparam int DIV_STEPS = DATA_W + 1;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  typedef struct packed {
    logic [DATA_W-1:0] min_val;
    logic [DATA_W-1:0] max_val;
    logic [RATE_W-1:0] rate;
    logic              present;
  } rti_entry_t;

  // Controller to datapath
  typedef struct packed {
    logic mem_write;
    logic query_start;
    logic scan_issue;
    logic rd_a;
    logic rd_b;
    logic cap_a;
    logic div_load;
    logic div_step;
    logic load_out;
  } rti_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_done;
    logic interp;
    logic div_last;
    logic out_free;
  } rti_sts_t;

endpackage

[design/rti_lane.sv]
// One interpolation lane: serial multiply-divide of the limit difference by num/den.
module rti_lane import rti_pkg::*; (
  input  logic              clk,
  input  logic              load,
  input  logic              step,
  input  logic [DATA_W-1:0] a,
  input  logic [DATA_W-1:0] b,
  input  logic [RATE_W-1:0] num,
  input  logic [RATE_W-1:0] den,
  output logic [DATA_W-1:0] result
);

  logic              neg_r;
  logic [DATA_W:0]   mag_r;
  logic [RATE_W-1:0] rem_r;
  logic [DATA_W:0]   quo_r;

  logic signed [DATA_W:0] diff;
  logic [RATE_W+1:0]      t_sum;
  logic [RATE_W+1:0]      t_red;
  logic [1:0]             digit;
  logic [DATA_W+1:0]      a_ext;
  logic [DATA_W+1:0]      q_adj;
  logic [DATA_W+1:0]      res_ext;

  // Signed difference of the two neighbor limits
  assign diff = $signed({b[DATA_W-1], b}) - $signed({a[DATA_W-1], a});

  // One step: remainder doubles, adds num for a set magnitude bit, then reduces by twice den or by den
  always_comb begin
    t_sum = {1'b0, rem_r, 1'b0} + (mag_r[DATA_W] ? {2'b00, num} : '0);
    if (t_sum >= {1'b0, den, 1'b0}) begin
      t_red = t_sum - {1'b0, den, 1'b0};
      digit = 2'd2;
    end else if (t_sum >= {2'b00, den}) begin
      t_red = t_sum - {2'b00, den};
      digit = 2'd1;
    end else begin
      t_red = t_sum;
      digit = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      neg_r <= diff[DATA_W];
      mag_r <= diff[DATA_W] ? (DATA_W + 1)'(-diff) : (DATA_W + 1)'(diff);
      rem_r <= '0;
      quo_r <= '0;
    end else if (step) begin
      mag_r <= {mag_r[DATA_W-1:0], 1'b0};
      rem_r <= t_red[RATE_W-1:0];
      quo_r <= {quo_r[DATA_W-1:0], 1'b0} + (DATA_W + 1)'(digit);
    end
  end

  // Floor toward minus infinity: a negative difference rounds its quotient up
  always_comb begin
    a_ext   = {a[DATA_W-1], a[DATA_W-1], a};
    q_adj   = (DATA_W + 2)'(quo_r) + (DATA_W + 2)'(neg_r && (rem_r != '0));
    res_ext = neg_r ? (a_ext - q_adj) : (a_ext + q_adj);
  end

  assign result = res_ext[DATA_W-1:0];

endmodule

[design/rti_dp.sv]
// Datapath: entry table, neighbor scan, two interpolation lanes and the result register.
module rti_dp import rti_pkg::*; #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  rti_cmd_t                 cmd,
  output rti_sts_t                 sts,
  input  logic [IDX_W-1:0]         in_entry_index,
  input  logic signed [DATA_W-1:0] in_min_value,
  input  logic signed [DATA_W-1:0] in_max_value,
  input  logic                     in_rate_given,
  input  logic [RATE_W-1:0]        in_rate_hz,
  input  logic                     cfg_wr_en,
  input  logic [CFG_W-1:0]         cfg_wr_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_found,
  output logic signed [DATA_W-1:0] out_lower_limit,
  output logic signed [DATA_W-1:0] out_upper_limit
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = ($clog2(TABLE_DEPTH + 1) > CFG_W) ? $clog2(TABLE_DEPTH + 1) : CFG_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  // Configuration and query context
  logic [CFG_W-1:0]  count_r;
  logic [CW-1:0]     n_r;
  logic [RATE_W-1:0] q_r;

  // Table memory
  rti_entry_t        mem_r [TABLE_DEPTH];
  rti_entry_t        rdata_r;
  rti_entry_t        wentry;
  logic [AW-1:0]     waddr;
  logic [AW-1:0]     raddr;
  logic              wr_ok;

  // Scan state
  logic [CW-1:0]     sidx_r;
  logic              scan_vld_r;
  logic [AW-1:0]     scan_tag_r;
  logic              lo_vld_r;
  logic              hi_vld_r;
  logic [AW-1:0]     lo_idx_r;
  logic [AW-1:0]     hi_idx_r;
  logic [RATE_W-1:0] rl_r;
  logic [RATE_W-1:0] rh_r;
  logic              lo_hit;
  logic              hi_hit;

  // Interpolation
  logic [AW-1:0]     sel_a;
  logic              interp;
  logic              found;
  logic [DATA_W-1:0] a_min_r;
  logic [DATA_W-1:0] a_max_r;
  logic [RATE_W-1:0] num_r;
  logic [RATE_W-1:0] den_r;
  logic [STEP_W-1:0] step_r;
  logic [DATA_W-1:0] lane_min;
  logic [DATA_W-1:0] lane_max;

  // Result register
  logic              out_valid_r;
  logic              out_found_r;
  logic [DATA_W-1:0] out_lower_r;
  logic [DATA_W-1:0] out_upper_r;

  // Entry count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cfg_wr_en) begin
      count_r <= cfg_wr_data;
    end
  end

  // Write port: slots beyond the table are dropped
  assign wr_ok  = cmd.mem_write && (CW'(in_entry_index) < DEPTH_C);
  assign waddr  = AW'(in_entry_index);
  assign wentry = '{min_val: in_min_value, max_val: in_max_value,
                    rate: in_rate_hz, present: in_rate_given};

  // Read address select
  always_comb begin
    raddr = sidx_r[AW-1:0];
    if (cmd.rd_a) begin
      raddr = sel_a;
    end else if (cmd.rd_b) begin
      raddr = hi_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem_r[waddr] <= wentry;
    end
    rdata_r <= mem_r[raddr];
  end

  // Nearest rated neighbors; strict compare keeps the first entry on ties
  assign lo_hit = scan_vld_r && rdata_r.present && (rdata_r.rate <= q_r) &&
                  (!lo_vld_r || (rl_r < rdata_r.rate));
  assign hi_hit = scan_vld_r && rdata_r.present && (rdata_r.rate >= q_r) &&
                  (!hi_vld_r || (rh_r > rdata_r.rate));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_vld_r <= 1'b0;
      lo_vld_r   <= 1'b0;
      hi_vld_r   <= 1'b0;
      sidx_r     <= '0;
    end else begin
      scan_vld_r <= cmd.scan_issue;
      if (cmd.query_start) begin
        sidx_r   <= '0;
        lo_vld_r <= 1'b0;
        hi_vld_r <= 1'b0;
      end else begin
        if (cmd.scan_issue) begin
          sidx_r <= sidx_r + 1'b1;
        end
        if (lo_hit) begin
          lo_vld_r <= 1'b1;
        end
        if (hi_hit) begin
          hi_vld_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.query_start) begin
      q_r <= in_rate_hz;
      n_r <= (CW'(count_r) > DEPTH_C) ? DEPTH_C : CW'(count_r);
    end
    if (cmd.scan_issue) begin
      scan_tag_r <= sidx_r[AW-1:0];
    end
    if (lo_hit) begin
      lo_idx_r <= scan_tag_r;
      rl_r     <= rdata_r.rate;
    end
    if (hi_hit) begin
      hi_idx_r <= scan_tag_r;
      rh_r     <= rdata_r.rate;
    end
  end

  // Outcome of the scan
  assign interp = lo_vld_r && hi_vld_r && (rh_r > rl_r);
  assign found  = lo_vld_r || hi_vld_r || (n_r != '0);

  always_comb begin
    if (lo_vld_r) begin
      sel_a = lo_idx_r;
    end else if (hi_vld_r) begin
      sel_a = hi_idx_r;
    end else begin
      sel_a = '0;
    end
  end

  // Lower neighbor (or the single entry) and fraction operands
  always_ff @(posedge clk) begin
    if (cmd.cap_a) begin
      a_min_r <= rdata_r.min_val;
      a_max_r <= rdata_r.max_val;
    end
    if (cmd.div_load) begin
      num_r <= q_r - rl_r;
      den_r <= rh_r - rl_r;
    end
  end

  // Step counter of the serial divide
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else if (cmd.div_load) begin
      step_r <= '0;
    end else if (cmd.div_step) begin
      step_r <= step_r + 1'b1;
    end
  end

  // Lanes start at div_load with the operand registers of that same edge,
  // so the first step follows in the next cycle and sees them settled
  rti_lane u_lane_min (
    .clk    (clk),
    .load   (cmd.div_load),
    .step   (cmd.div_step),
    .a      (a_min_r),
    .b      (rdata_r.min_val),
    .num    (num_r),
    .den    (den_r),
    .result (lane_min)
  );

  rti_lane u_lane_max (
    .clk    (clk),
    .load   (cmd.div_load),
    .step   (cmd.div_step),
    .a      (a_max_r),
    .b      (rdata_r.max_val),
    .num    (num_r),
    .den    (den_r),
    .result (lane_max)
  );

  // Result register with its valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_found_r <= found;
      if (!found) begin
        out_lower_r <= '0;
        out_upper_r <= '0;
      end else if (interp) begin
        out_lower_r <= lane_min;
        out_upper_r <= lane_max;
      end else begin
        out_lower_r <= a_min_r;
        out_upper_r <= a_max_r;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_lower_limit = out_lower_r;
  assign out_upper_limit = out_upper_r;

  // Status to the controller
  assign sts.scan_done = (sidx_r == n_r);
  assign sts.interp    = interp;
  assign sts.div_last  = (step_r == STEP_W'(DIV_STEPS - 1));
  assign sts.out_free  = !out_valid_r || !out_stall;

endmodule

[design/rti_ctrl.sv]
// Controller: sequences table writes, the scan, neighbor reads, the divide and the result load.
module rti_ctrl import rti_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_op,
  output logic     in_stall,
  input  rti_sts_t sts,
  output rti_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_RDA  = 3'd2;
  localparam logic [2:0] ST_RDB  = 3'd3;
  localparam logic [2:0] ST_LOAD = 3'd4;
  localparam logic [2:0] ST_DIV  = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Items enter only while idle
  assign in_stall = (state_r != ST_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_op == OP_WRITE) begin
            cmd.mem_write = 1'b1;
          end else begin
            cmd.query_start = 1'b1;
            state_nxt       = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // last read is evaluated in the cycle that sees scan_done
        if (!sts.scan_done) begin
          cmd.scan_issue = 1'b1;
        end else begin
          state_nxt = ST_RDA;
        end
      end
      ST_RDA: begin
        cmd.rd_a  = 1'b1;
        state_nxt = ST_RDB;
      end
      ST_RDB: begin
        cmd.rd_b  = 1'b1;
        cmd.cap_a = 1'b1;
        state_nxt = sts.interp ? ST_LOAD : ST_FIN;
      end
      ST_LOAD: begin
        cmd.div_load = 1'b1;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

[design/rate_threshold_interpolator.sv]
// Top level of the rate threshold interpolator.
// Write item: taken back to back; no result.
// Query item: a table scan over n entries at one entry per cycle, where n is the clamped
// entry count, then the neighbor reads and, with interpolation, the 33-step serial
// multiply-divide; the block then waits while an earlier result stays stalled.
// Reset clears the controller, the entry count and the result valid; table is unset.
module rate_threshold_interpolator import rti_pkg::*; #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_op,
  input  logic [IDX_W-1:0]         in_entry_index,
  input  logic signed [DATA_W-1:0] in_min_value,
  input  logic signed [DATA_W-1:0] in_max_value,
  input  logic                     in_rate_given,
  input  logic [RATE_W-1:0]        in_rate_hz,
  input  logic                     cfg_wr_en,
  input  logic [CFG_W-1:0]         cfg_wr_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_found,
  output logic signed [DATA_W-1:0] out_lower_limit,
  output logic signed [DATA_W-1:0] out_upper_limit
);

  rti_cmd_t cmd;
  rti_sts_t sts;

  rti_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_op),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  rti_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_entry_index  (in_entry_index),
    .in_min_value    (in_min_value),
    .in_max_value    (in_max_value),
    .in_rate_given   (in_rate_given),
    .in_rate_hz      (in_rate_hz),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_found       (out_found),
    .out_lower_limit (out_lower_limit),
    .out_upper_limit (out_upper_limit)
  );

endmodule

[design/rti_checker.sv]
// Port-level checker of the rate threshold interpolator, bound to the top level.
`include "rate_threshold_interpolator_assert.svh"

module rti_checker import rti_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic                     in_op,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic                     out_found,
  input logic signed [DATA_W-1:0] out_lower_limit,
  input logic signed [DATA_W-1:0] out_upper_limit
);

  // A write transfer completes at once; a query transfer holds off the input
  `RTI_ASSERT_NXT(a_write_no_stall, clk, rst_n, in_valid && !in_stall && (in_op == OP_WRITE), !in_stall, "write transfer stalled the input")
  `RTI_ASSERT_NXT(a_query_busy, clk, rst_n, in_valid && !in_stall && (in_op == OP_QUERY), in_stall, "query transfer did not occupy the block")

  // Not-found results carry zero limits
  `RTI_ASSERT_IMP(a_notfound_zero, clk, rst_n, out_valid && !out_found, (out_lower_limit == '0) && (out_upper_limit == '0), "not-found result with nonzero limits")

  // A stalled result holds
  `RTI_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_lower_limit) && $stable(out_upper_limit) && $stable(out_found), "stalled result changed")

endmodule

bind rate_threshold_interpolator rti_checker u_rti_checker (.*);

[tb/sv/rate_threshold_interpolator_checker.sv]
// Checker for the rate threshold interpolator: tracks the table, predicts limits, compares.
module rate_threshold_interpolator_checker import rti_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic                     in_op,
  input  logic [IDX_W-1:0]         in_entry_index,
  input  logic signed [DATA_W-1:0] in_min_value,
  input  logic signed [DATA_W-1:0] in_max_value,
  input  logic                     in_rate_given,
  input  logic [RATE_W-1:0]        in_rate_hz,
  input  logic                     cfg_wr_en,
  input  logic [CFG_W-1:0]         cfg_wr_data,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic                     out_found,
  input  logic signed [DATA_W-1:0] out_lower_limit,
  input  logic signed [DATA_W-1:0] out_upper_limit,
  output int                       pending,
  output int                       fail_count,
  output int                       checked_count,
  output int                       blend_count
);

  typedef struct packed {
    logic                     found;
    logic signed [DATA_W-1:0] lower;
    logic signed [DATA_W-1:0] upper;
  } limits_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] min_thr;
    logic signed [DATA_W-1:0] max_thr;
    logic [RATE_W-1:0]        rate;
    logic                     rated;
  } slot_t;

  slot_t            slots [DEPTH];
  logic [CFG_W-1:0] active_count;
  limits_t          expected_limits [$];
  int               mismatches;
  int               checked;
  int               blended;

  // from + floor((to - from) * num / den), exact; 0 <= num <= den, den > 0
  function automatic logic signed [DATA_W-1:0] blend(input logic signed [DATA_W-1:0] from_thr,
                                                     input logic signed [DATA_W-1:0] to_thr,
                                                     input logic [RATE_W-1:0] num,
                                                     input logic [RATE_W-1:0] den);
    logic signed [33:0] span;
    logic signed [66:0] prod;
    logic signed [66:0] divisor;
    logic signed [66:0] quo;
    span = {{2{to_thr[31]}}, to_thr} - {{2{from_thr[31]}}, from_thr};
    prod = span * $signed({1'b0, num});
    divisor = $signed({35'd0, den});
    // division truncates toward zero; step down for a negative inexact quotient
    quo = prod / divisor;
    if (prod < 0 && quo * divisor != prod) quo = quo - 1;
    return from_thr + quo[DATA_W-1:0];
  endfunction

  // Nearest rated neighbors of q among the scanned entries, then the limits
  function automatic limits_t lookup(input logic [RATE_W-1:0] q, output bit mixed);
    int                span_n;
    int                below;
    int                above;
    logic [RATE_W-1:0] r_below;
    logic [RATE_W-1:0] r_above;
    limits_t           res;
    span_n = (active_count > DEPTH) ? DEPTH : int'(active_count);
    below = -1;
    above = -1;
    r_below = '0;
    r_above = '0;
    res = '0;
    mixed = 1'b0;
    for (int i = 0; i < span_n; i++) begin
      if (!slots[i].rated) continue;
      // strict compares keep the first entry on a tie
      if (slots[i].rate <= q && (below < 0 || r_below < slots[i].rate)) begin
        below = i;
        r_below = slots[i].rate;
      end
      if (slots[i].rate >= q && (above < 0 || r_above > slots[i].rate)) begin
        above = i;
        r_above = slots[i].rate;
      end
    end
    if (below >= 0 && above >= 0 && below != above && r_above > r_below) begin
      mixed = 1'b1;
      res.found = 1'b1;
      res.lower = blend(slots[below].min_thr, slots[above].min_thr, q - r_below,
                        r_above - r_below);
      res.upper = blend(slots[below].max_thr, slots[above].max_thr, q - r_below,
                        r_above - r_below);
    end else if (below >= 0) begin
      res = '{1'b1, slots[below].min_thr, slots[below].max_thr};
    end else if (above >= 0) begin
      res = '{1'b1, slots[above].min_thr, slots[above].max_thr};
    end else if (span_n > 0) begin
      // no rated entry: fall back to entry 0
      res = '{1'b1, slots[0].min_thr, slots[0].max_thr};
    end
    return res;
  endfunction

  always @(posedge clk) begin
    limits_t want;
    bit      mixed;
    if (!rst_n) begin
      active_count = '0;
      expected_limits.delete();
    end else begin
      // register write
      if (cfg_wr_en) active_count = cfg_wr_data;

      // input transfer: update the table or queue the predicted limits
      if (in_valid && !in_stall) begin
        if (in_op == OP_WRITE) begin
          slots[in_entry_index] = '{in_min_value, in_max_value, in_rate_hz, in_rate_given};
        end else begin
          want = lookup(in_rate_hz, mixed);
          if (mixed) blended++;
          expected_limits.push_back(want);
        end
      end

      // result transfer: compare against the oldest prediction
      if (out_valid && !out_stall) begin
        if (expected_limits.size() == 0) begin
          $display("%0t: result transfer with nothing expected, got found=%0b lower=%0d upper=%0d",
                   $time, out_found, out_lower_limit, out_upper_limit);
          mismatches++;
        end else begin
          want = expected_limits.pop_front();
          checked++;
          if (out_found !== want.found || out_lower_limit !== want.lower ||
              out_upper_limit !== want.upper) begin
            $display("%0t: limits mismatch, expected found=%0b lower=%0d upper=%0d",
                     $time, want.found, want.lower, want.upper);
            $display("%0t:                  actual   found=%0b lower=%0d upper=%0d",
                     $time, out_found, out_lower_limit, out_upper_limit);
            mismatches++;
          end
        end
      end
    end
    pending       <= expected_limits.size();
    fail_count    <= mismatches;
    checked_count <= checked;
    blend_count   <= blended;
  end

endmodule

[tb/sv/rate_threshold_interpolator_test.sv]
// Top of the rate threshold interpolator testbench: clock, reset, stimulus and verdict.
module rate_threshold_interpolator_test;
  import rti_pkg::*;

  localparam int LIMIT_CYCLES      = 1_000_000;
  localparam int SETTLE_CYCLES     = 64;
  localparam int ITEMS_PER_SETTING = 160;

  logic                     clk             = 1'b0;
  logic                     rst_n           = 1'b0;
  logic                     in_valid        = 1'b0;
  logic                     in_stall;
  logic                     in_op           = OP_WRITE;
  logic [IDX_W-1:0]         in_entry_index  = '0;
  logic signed [DATA_W-1:0] in_min_value    = '0;
  logic signed [DATA_W-1:0] in_max_value    = '0;
  logic                     in_rate_given   = 1'b0;
  logic [RATE_W-1:0]        in_rate_hz      = '0;
  logic                     cfg_wr_en       = 1'b0;
  logic [CFG_W-1:0]         cfg_wr_data     = '0;
  logic                     out_valid;
  logic                     out_stall       = 1'b0;
  logic                     out_found;
  logic signed [DATA_W-1:0] out_lower_limit;
  logic signed [DATA_W-1:0] out_upper_limit;

  int pending;
  int fail_count;
  int checked_count;
  int blend_count;
  int send_idle_pct;
  int stall_pct;
  int cycle_count;
  int writes_sent;
  int queries_sent;

  always #2 clk = ~clk;

  rate_threshold_interpolator u_dut (.*);

  rate_threshold_interpolator_checker u_check (.*);

  // receiver back-pressure
  always @(posedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  // run watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  // threshold values, weighted toward the extremes, small values and zero
  function automatic logic [DATA_W-1:0] pick_threshold();
    case ($urandom_range(9))
      6:       return 32'h8000_0000;
      7:       return 32'h7FFF_FFFF;
      8:       return 32'($urandom_range(200)) - 32'd100;
      9:       return '0;
      default: return $urandom;
    endcase
  endfunction

  // one input transfer, with random idle cycles ahead of it
  task automatic send_item(input logic op, input logic [IDX_W-1:0] idx,
                           input logic [DATA_W-1:0] min_v, input logic [DATA_W-1:0] max_v,
                           input logic given, input logic [RATE_W-1:0] rate);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_op          <= op;
    in_entry_index <= idx;
    in_min_value   <= min_v;
    in_max_value   <= max_v;
    in_rate_given  <= given;
    in_rate_hz     <= rate;
    do @(posedge clk); while (in_stall);
    if (op == OP_WRITE) writes_sent++;
    else queries_sent++;
  endtask

  // query with random content in the fields that a query ignores
  task automatic ask(input logic [RATE_W-1:0] rate);
    send_item(OP_QUERY, IDX_W'($urandom_range(15)), $urandom, $urandom,
              1'($urandom_range(1)), rate);
  endtask

  // hold off the sender until every predicted result has arrived
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // entry count write, only once the block has gone quiet
  task automatic set_count(input logic [CFG_W-1:0] value);
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // random write or query; small rates give exact hits and ties
  task automatic random_item();
    logic [RATE_W-1:0] rate;
    case ($urandom_range(9))
      0, 1, 2, 3: rate = $urandom;
      4, 5, 6, 7: rate = $urandom_range(40);
      8:          rate = 32'hFFFF_FFFF - $urandom_range(40);
      default:    rate = 32'h8000_0000 + $urandom_range(80) - 32'd40;
    endcase
    if ($urandom_range(99) < 35) begin
      send_item(OP_WRITE, IDX_W'($urandom_range(15)), pick_threshold(), pick_threshold(),
                $urandom_range(99) < 80, rate);
    end else begin
      ask(rate);
    end
  endtask

  initial begin
    int count_plan [8];
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // empty table: count is zero out of reset
    ask(32'd123);

    // only entry 0, without a rate: fallback to entry 0
    send_item(OP_WRITE, 4'd0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 32'd777);
    set_count(5'd1);
    ask(32'd777);

    // a single rated entry: neighbor only above, then only below
    send_item(OP_WRITE, 4'd1, 32'd10, 32'd20, 1'b1, 32'd2000);
    set_count(5'd2);
    ask(32'd5);
    ask(32'd9000);

    // rate extremes, reversed limits, a tie and an entry without a rate
    send_item(OP_WRITE, 4'd2, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 32'd0);
    send_item(OP_WRITE, 4'd3, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 32'hFFFF_FFFF);
    send_item(OP_WRITE, 4'd4, 32'd100, -32'sd100, 1'b1, 32'd1000);
    send_item(OP_WRITE, 4'd5, 32'd5, 32'd5, 1'b1, 32'd1000);
    send_item(OP_WRITE, 4'd6, -32'sd50, 32'd250, 1'b0, 32'd1500);
    set_count(5'd7);
    ask(32'd0);
    ask(32'hFFFF_FFFF);
    ask(32'd1000);
    ask(32'd1500);
    ask(32'd999);
    ask(32'hFFFF_FFFE);
    ask(32'h8000_0000);

    // fill the rest of the table, then an oversized count
    for (int i = 7; i < 16; i++) begin
      send_item(OP_WRITE, IDX_W'(i), pick_threshold(), pick_threshold(), 1'b1, $urandom);
    end
    set_count(5'd31);
    ask($urandom);

    // random traffic: four idling profiles, two entry counts each
    count_plan = '{16, 3, 31, 0, 17 + $urandom_range(13), 1, 16, 2 + $urandom_range(13)};
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 46; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 46; end
        default: begin send_idle_pct = 37; stall_pct = 37; end
      endcase
      for (int half = 0; half < 2; half++) begin
        set_count(CFG_W'(count_plan[ph * 2 + half]));
        repeat (ITEMS_PER_SETTING) begin
          if ($urandom_range(99) == 0) wait_idle();
          random_item();
        end
      end
    end

    // drain and let the block settle
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("summary: %0d table writes and %0d queries, entry counts 0 through 31",
             writes_sent, queries_sent);
    $display("summary: %0d results compared, %0d of them interpolated between two entries",
             checked_count, blend_count);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+design
design/rti_pkg.sv
design/rti_lane.sv
design/rti_dp.sv
design/rti_ctrl.sv
design/rate_threshold_interpolator.sv
design/rti_checker.sv
tb/sv/rate_threshold_interpolator_checker.sv
tb/sv/rate_threshold_interpolator_test.sv
